// ===== sv/cdp_pkg.sv =====
`default_nettype none

package cdp_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DOW_W   = 3;
  localparam int DOY_W   = 9;

  // floor(y / 100) == (y * RECIP100) >> RECIP100_SHIFT for every 14-bit y
  localparam int RECIP100       = 5243;
  localparam int RECIP100_W     = 13;
  localparam int RECIP100_SHIFT = 19;

  // Multiple of 7 that stays above any century count, keeps the weekday sum positive
  localparam int CENTURY_BIAS = 168;
  localparam int YEAR_OFFSET  = 400;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DOW_W-1:0] DOW_FRI = 3'd5;
  localparam logic [DOW_W-1:0] DOW_SAT = 3'd6;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_in_t;

  typedef struct packed {
    logic               valid_res;
    logic               leap_year;
    logic [DAY_W-1:0]   days_in_month;
    logic [DOW_W-1:0]   day_of_week;
    logic [DOY_W-1:0]   day_of_year;
    logic               weekend;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
    logic [DAY_W-1:0]   prev_day;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
  } date_res_t;

  // Month length, 0 for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // Days before the first of month m in a common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // (31 * mm) / 12 with March as month 1 (Jan, Feb are months 11, 12)
  function automatic logic [DAY_W-1:0] month_key(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // x mod 7 by octal digit sums (8 = 1 mod 7)
  function automatic logic [DOW_W-1:0] mod7(input logic [15:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[DOW_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_date_properties_unit.sv =====
`default_nettype none

// Calendar date properties unit.
// Input channel (in_valid / in_ready / in_data) takes one Gregorian date per
// transaction: day, month, year. Output channel (out_valid / out_ready /
// out_data) returns one result transaction per date: validity, leap year,
// month length, day of week (0 = Sunday), day of year, weekend flag
// (Friday or Saturday), and the next and previous dates with rollover.
// Invalid dates give zero weekday and ordinal and echo the input date as
// next and previous date.
// Input register, then result register. Throughput: one transaction per
// cycle while the receiver accepts; the path between the registers holds
// one 14x13 constant multiply (year / 100 by reciprocal) and the weekday
// sum mod 7. When the receiver stalls, the result register holds and the
// input register still takes one more date; in_ready drops once both are
// full. Reset (rst, synchronous) empties both stages; data is not reset.

module calendar_date_properties_unit
  import cdp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire date_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output date_res_t      out_data
);

  localparam int PROD_W = YEAR_W + RECIP100_W;
  localparam int Q_W    = PROD_W - RECIP100_SHIFT;
  localparam int YY_W   = YEAR_W + 1;

  // Input stage
  logic      stage_vld;
  date_in_t  stage_date;
  logic      advance;

  // Result stage advances when empty or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_vld <= in_valid;
      end
      if (advance) begin
        out_valid <= stage_vld;
      end
    end
  end

  date_res_t res_next;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_date <= in_data;
    end
    if (advance && stage_vld) begin
      out_data <= res_next;
    end
  end

  // Date logic
  logic [DAY_W-1:0]   d;
  logic [MONTH_W-1:0] m;
  logic [YEAR_W-1:0]  y;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q;       // year / 100
  logic               div100;  // year % 100 == 0
  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic               valid;
  logic               jan_feb;
  logic [YY_W-1:0]    yy;
  logic [Q_W-1:0]     qq;      // yy / 100
  logic [15:0]        wsum;
  logic [DOW_W-1:0]   dow;

  assign d = stage_date.day;
  assign m = stage_date.month;
  assign y = stage_date.year;

  assign prod = PROD_W'(y) * PROD_W'(RECIP100);
  assign q    = prod[PROD_W-1:RECIP100_SHIFT];
  // Fraction below one reciprocal step only for exact multiples of 100
  assign div100 = prod[RECIP100_SHIFT-1:0] < RECIP100_SHIFT'(RECIP100);

  assign leap  = ((y[1:0] == 2'd0) && !div100) || (div100 && (q[1:0] == 2'd0));
  assign dim   = month_days(m, leap);
  assign valid = (dim != 5'd0) && (d != 5'd0) && (d <= dim);

  // January and February count as months of the previous year
  assign jan_feb = (m == MONTH_JAN) || (m == MONTH_FEB);
  assign yy = YY_W'(y) + YY_W'(YEAR_OFFSET) - YY_W'(jan_feb);
  assign qq = q + Q_W'(YEAR_OFFSET / 100) - Q_W'(jan_feb && div100);

  assign wsum = 16'(d) + 16'(yy) + 16'(yy >> 2) + 16'(qq >> 2)
              + 16'(CENTURY_BIAS) - 16'(qq) + 16'(month_key(m));
  assign dow  = valid ? mod7(wsum) : 3'd0;

  always_comb begin
    res_next               = '0;
    res_next.valid_res     = valid;
    res_next.leap_year     = leap;
    res_next.days_in_month = dim;
    res_next.day_of_week   = dow;
    res_next.day_of_year   = valid ? (cum_days(m) + DOY_W'(leap && (m > MONTH_FEB)) + DOY_W'(d))
                                   : '0;
    res_next.weekend       = (dow == DOW_FRI) || (dow == DOW_SAT);
    res_next.next_day      = d;
    res_next.next_month    = m;
    res_next.next_year     = y;
    res_next.prev_day      = d;
    res_next.prev_month    = m;
    res_next.prev_year     = y;
    if (valid) begin
      if (d == dim) begin
        res_next.next_day = 5'd1;
        if (m == MONTH_DEC) begin
          res_next.next_month = MONTH_JAN;
          res_next.next_year  = y + 1'b1;
        end else begin
          res_next.next_month = m + 1'b1;
        end
      end else begin
        res_next.next_day = d + 1'b1;
      end
      if (d == 5'd1) begin
        if (m == MONTH_JAN) begin
          res_next.prev_day   = 5'd31;
          res_next.prev_month = MONTH_DEC;
          res_next.prev_year  = y - 1'b1;
        end else begin
          res_next.prev_month = m - 1'b1;
          res_next.prev_day   = month_days(m - 1'b1, leap);
        end
      end else begin
        res_next.prev_day = d - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !stage_vld)
    else $error("pipeline not empty after reset");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_vld && !advance |=> stage_vld && $stable(stage_date))
    else $error("input stage lost a date during stall");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.valid_res |->
      out_data.day_of_week == 3'd0 && out_data.day_of_year == 9'd0 &&
      out_data.next_day == out_data.prev_day)
    else $error("invalid date produced nonzero properties");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.valid_res |->
      out_data.day_of_week <= DOW_SAT && out_data.day_of_year != 9'd0 &&
      out_data.day_of_year <= 9'd365 + 9'(out_data.leap_year))
    else $error("weekday or ordinal out of range");

  a_move_out: assert property (@(posedge clk) disable iff (rst)
    stage_vld && advance |=> out_valid)
    else $error("result stage dropped a transaction");
`endif

endmodule

`default_nettype wire
